// ===== design/assert_macros.svh =====
// Assertion macros for the framebuffer RTL, used by the controller.
// Clock and reset are taken from the enclosing module: clock, reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every clock edge outside reset
`define LSF_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Condition that must never be true outside reset
`define LSF_ASSERT_NEVER(label, expr, msg) \
   label: assert property (@(posedge clock) disable iff (reset) !(expr)) else $error(msg);

`endif

// ===== design/lsf_pkg.sv =====
// Package for the LCD sprite framebuffer: geometry constants, opcodes,
// controller states and the command/status structs between controller and datapath.
package lsf_pkg;

   localparam int SCREEN_WIDTH  = 84;
   localparam int SCREEN_HEIGHT = 48;
   localparam int SPRITE_COUNT  = 32;
   localparam int SLOT_COUNT    = 32;

   localparam int COL_BYTES    = (SCREEN_HEIGHT + 7) / 8;
   localparam int FRAME_BYTES  = SCREEN_WIDTH * COL_BYTES;
   localparam int FRAME_AW     = $clog2(FRAME_BYTES);
   localparam int SPR_IW       = (SPRITE_COUNT > 1) ? $clog2(SPRITE_COUNT) : 1;
   localparam int SLOT_IW      = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
   localparam int SPRITE_BYTES = SPRITE_COUNT * 8;
   localparam int SPR_AW       = SPR_IW + 3;

   typedef enum logic [2:0] {
      OP_PIXEL    = 3'd0,
      OP_COLUMN   = 3'd1,
      OP_LOAD     = 3'd2,
      OP_PLACE    = 3'd3,
      OP_CLR_SLOT = 3'd4,
      OP_MOVE     = 3'd5,
      OP_READ     = 3'd6,
      OP_CLEAR    = 3'd7
   } op_type;

   typedef enum logic [3:0] {
      S_INIT,
      S_IDLE,
      S_RD0,
      S_WR0,
      S_WR1,
      S_READ,
      S_CLEAR,
      S_DONE
   } state_type;

   typedef enum logic [1:0] {
      RD_REQ,
      RD_B0,
      RD_B1
   } rd_src_type;

   typedef struct packed {
      logic       capture;
      logic       load_rsp;
      logic       frame_we_b0;
      logic       frame_we_b1;
      logic       clear_we;
      logic       spr_clear;
      logic       sprite_rd;
      logic       col_inc;
      rd_src_type rd_src;
   } cmd_type;

   typedef struct packed {
      op_type req_op;
      logic   move_ok;
      logic   col_last;
      logic   clear_last;
   } status_type;

endpackage

// ===== design/lsf_if.sv =====
// Valid/ready channel interfaces for the framebuffer request and response.
// Standalone; payload widths follow the request and response fields.
interface lsf_req_if;
   logic       valid;
   logic       ready;
   logic [2:0] op;
   logic [7:0] x_pos;
   logic [7:0] y_pos;
   logic [7:0] value;
   logic [5:0] sprite_ref;
   logic [4:0] slot;
   logic [2:0] row;
   logic [8:0] address;

   modport source (
      output valid, op, x_pos, y_pos, value, sprite_ref, slot, row, address,
      input  ready
   );
   modport sink (
      input  valid, op, x_pos, y_pos, value, sprite_ref, slot, row, address,
      output ready
   );
endinterface

interface lsf_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] read_data;
   logic       bad_request;

   modport source (output valid, read_data, bad_request, input ready);
   modport sink (input valid, read_data, bad_request, output ready);
endinterface

// ===== design/lcd_sprite_framebuffer_unit.sv =====
// LCD sprite framebuffer, 84x48 one-bit, column-major, with 32 sprites and 32 slots.
// States after accept: pixel/column RD0, WR0, WR1, DONE; read READ, DONE; load, place and
// clear slot straight to DONE; move+draw RD0, WR0, WR1 per sprite column through the frame RAM
// port; empty slot move DONE; frame clear CLEAR over all bytes. One transaction in flight;
// next accepted on return to idle. Synchronous active-high reset; afterwards a clearing pass
// zeroes the frame and sprite RAMs while no request is taken. The slot table clears at once.
module lcd_sprite_framebuffer_unit import lsf_pkg::*; (
   input logic       clock,
   input logic       reset,
   lsf_req_if.sink   req_port,
   lsf_rsp_if.source rsp_port
);

   cmd_type    cmd;
   status_type status;

   lsf_datapath u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .req_op          (req_port.op),
      .req_x_pos       (req_port.x_pos),
      .req_y_pos       (req_port.y_pos),
      .req_value       (req_port.value),
      .req_sprite_ref  (req_port.sprite_ref),
      .req_slot        (req_port.slot),
      .req_row         (req_port.row),
      .req_address     (req_port.address),
      .rsp_read_data   (rsp_port.read_data),
      .rsp_bad_request (rsp_port.bad_request)
   );

   lsf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_port.valid),
      .req_ready (req_port.ready),
      .rsp_ready (rsp_port.ready),
      .rsp_valid (rsp_port.valid),
      .cmd       (cmd),
      .status    (status)
   );

endmodule

// ===== design/lsf_datapath.sv =====
// Datapath: frame memory with read-modify-write merge, sprite memory, slot table,
// request capture and response register. Uses lsf_pkg; driven by lsf_ctrl commands.
module lsf_datapath import lsf_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  cmd_type    cmd,
   output status_type status,
   input  logic [2:0] req_op,
   input  logic [7:0] req_x_pos,
   input  logic [7:0] req_y_pos,
   input  logic [7:0] req_value,
   input  logic [5:0] req_sprite_ref,
   input  logic [4:0] req_slot,
   input  logic [2:0] req_row,
   input  logic [8:0] req_address,
   output logic [7:0] rsp_read_data,
   output logic       rsp_bad_request
);

   function automatic logic ref_ok(input logic [5:0] r);
      return (r != 6'd0) && (7'(r) <= 7'(SPRITE_COUNT));
   endfunction

   logic [7:0] frame_mem [FRAME_BYTES];
   logic [7:0] spr_mem [SPRITE_BYTES];
   logic [5:0] slot_ref_ff [SLOT_COUNT];

   op_type        op_ff;
   logic [7:0]    x_ff;
   logic [7:0]    y_ff;
   logic [7:0]    value_ff;
   logic [5:0]    ref_ff;
   logic [8:0]    addr_ff;
   logic          in_range_ff;
   logic          bad_ff;
   logic [2:0]    col_ff;
   logic [FRAME_AW-1:0] clr_ff;
   logic [7:0]    rdata_ff;
   logic [7:0]    spr_rdata_ff;
   logic [7:0]    rsp_read_data_ff;
   logic          rsp_bad_ff;

   op_type        op_req;
   logic          slot_ok;
   logic [SLOT_IW-1:0] slot_idx;
   logic [5:0]    slot_ref_cur;
   logic [5:0]    wr_ref_m1;
   logic [5:0]    rd_ref_m1;
   logic [SPR_IW-1:0] wr_sidx;
   logic [SPR_IW-1:0] rd_sidx;
   logic          spr_we;
   logic [SPR_AW-1:0] spr_wr_addr;
   logic [SPR_AW-1:0] spr_rd_addr;

   logic [7:0]    x_col;
   logic [7:0]    col_data;
   logic [7:0]    col_mask;
   logic [15:0]   row_ok;
   logic          x_ok;
   logic [15:0]   data_sh;
   logic [15:0]   mask_sh;
   logic [15:0]   base;
   logic [15:0]   base_b1;
   logic [15:0]   addr_ext;

   logic          frame_we;
   logic [FRAME_AW-1:0] wr_addr;
   logic [FRAME_AW-1:0] rd_addr;
   logic [7:0]    wr_data;

   // Request decode
   assign op_req       = op_type'(req_op);
   assign slot_ok      = 7'(req_slot) < 7'(SLOT_COUNT);
   assign slot_idx     = SLOT_IW'(req_slot);
   assign slot_ref_cur = slot_ref_ff[slot_idx];
   assign wr_ref_m1    = req_sprite_ref - 6'd1;
   assign wr_sidx      = SPR_IW'(wr_ref_m1);
   assign rd_ref_m1    = ref_ff - 6'd1;
   assign rd_sidx      = SPR_IW'(rd_ref_m1);
   assign spr_we       = cmd.capture && (op_req == OP_LOAD) && ref_ok(req_sprite_ref);
   assign spr_wr_addr  = cmd.spr_clear ? clr_ff[SPR_AW-1:0] : {wr_sidx, req_row};
   assign spr_rd_addr  = {rd_sidx, col_ff};

   assign status.req_op     = op_req;
   assign status.move_ok    = slot_ok && ref_ok(slot_ref_cur);
   assign status.col_last   = (op_ff != OP_MOVE) || (col_ff == 3'd7);
   assign status.clear_last = clr_ff == FRAME_AW'(FRAME_BYTES - 1);

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff       <= op_req;
         x_ff        <= req_x_pos;
         y_ff        <= req_y_pos;
         value_ff    <= req_value;
         ref_ff      <= slot_ref_cur;
         addr_ff     <= req_address;
         in_range_ff <= 16'(req_address) < 16'(FRAME_BYTES);
         bad_ff      <= (op_req == OP_LOAD) && !ref_ok(req_sprite_ref);
      end
   end

   // Slot table; only the sprite ref of a slot is ever read back
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < SLOT_COUNT; s++) begin
            slot_ref_ff[s] <= 6'd0;
         end
      end else if (cmd.capture && slot_ok) begin
         if (op_req == OP_PLACE) begin
            slot_ref_ff[slot_idx] <= req_sprite_ref;
         end else if (op_req == OP_CLR_SLOT) begin
            slot_ref_ff[slot_idx] <= 6'd0;
         end
      end
   end

   // Zero the sprite memory during the clearing pass after reset; one row per load
   always_ff @(posedge clock) begin
      if (cmd.spr_clear) begin
         spr_mem[spr_wr_addr] <= 8'h00;
      end else if (spr_we) begin
         spr_mem[spr_wr_addr] <= req_value;
      end
      if (cmd.sprite_rd) begin
         spr_rdata_ff <= spr_mem[spr_rd_addr];
      end
   end

   // Column geometry: one 8-pixel column spans at most two frame bytes
   always_comb begin
      x_col = x_ff + {5'b00000, col_ff};
      case (op_ff)
         OP_PIXEL: begin
            col_data = {7'b0000000, value_ff[0]};
            col_mask = 8'h01;
         end
         OP_COLUMN: begin
            col_data = value_ff;
            col_mask = 8'hFF;
         end
         OP_MOVE: begin
            col_data = spr_rdata_ff;
            col_mask = 8'hFF;
         end
         default: begin
            col_data = 8'h00;
            col_mask = 8'h00;
         end
      endcase
      for (int b = 0; b < 16; b++) begin
         row_ok[b] = (9'({y_ff[7:3], 3'b000}) + 9'(b)) < 9'(SCREEN_HEIGHT);
      end
      x_ok    = 9'(x_col) < 9'(SCREEN_WIDTH);
      data_sh = 16'(col_data) << y_ff[2:0];
      mask_sh = (16'(col_mask) << y_ff[2:0]) & row_ok & {16{x_ok}};
      base    = 16'(x_col) * 16'(COL_BYTES) + 16'(y_ff[7:3]);
      base_b1 = base + 16'd1;
   end

   assign addr_ext = 16'(addr_ff);

   always_comb begin
      frame_we = 1'b0;
      wr_addr  = clr_ff;
      wr_data  = 8'h00;
      if (cmd.clear_we) begin
         frame_we = 1'b1;
      end else if (cmd.frame_we_b0 && (mask_sh[7:0] != 8'h00)) begin
         frame_we = 1'b1;
         wr_addr  = base[FRAME_AW-1:0];
         wr_data  = (rdata_ff & ~mask_sh[7:0]) | (data_sh[7:0] & mask_sh[7:0]);
      end else if (cmd.frame_we_b1 && (mask_sh[15:8] != 8'h00)) begin
         frame_we = 1'b1;
         wr_addr  = base_b1[FRAME_AW-1:0];
         wr_data  = (rdata_ff & ~mask_sh[15:8]) | (data_sh[15:8] & mask_sh[15:8]);
      end
   end

   always_comb begin
      case (cmd.rd_src)
         RD_B0:   rd_addr = base[FRAME_AW-1:0];
         RD_B1:   rd_addr = base_b1[FRAME_AW-1:0];
         default: rd_addr = addr_ext[FRAME_AW-1:0];
      endcase
   end

   always_ff @(posedge clock) begin
      if (frame_we) begin
         frame_mem[wr_addr] <= wr_data;
      end
      rdata_ff <= frame_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= 3'd0;
         clr_ff <= '0;
      end else if (cmd.capture) begin
         col_ff <= 3'd0;
         clr_ff <= '0;
      end else begin
         if (cmd.col_inc) begin
            col_ff <= col_ff + 3'd1;
         end
         if (cmd.clear_we) begin
            clr_ff <= clr_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_rsp) begin
         rsp_read_data_ff <= ((op_ff == OP_READ) && in_range_ff) ? rdata_ff : 8'h00;
         rsp_bad_ff       <= bad_ff;
      end
   end

   assign rsp_read_data   = rsp_read_data_ff;
   assign rsp_bad_request = rsp_bad_ff;

endmodule

// ===== design/lsf_ctrl.sv =====
// Controller: state machine sequencing frame clear sweeps, sprite fetch and
// per-column read-modify-write. Uses lsf_pkg and assert_macros.svh.
`include "assert_macros.svh"

module lsf_ctrl import lsf_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic       rsp_ready,
   output logic       rsp_valid,
   output cmd_type    cmd,
   input  status_type status
);

   state_type state_ff;
   state_type state_in;
   logic      rsp_valid_ff;
   logic      accept;
   logic      rsp_free;

   assign req_ready = state_ff == S_IDLE;
   assign accept    = req_valid && req_ready;
   assign rsp_free  = !rsp_valid_ff || rsp_ready;
   assign rsp_valid = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_INIT;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load_rsp) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      cmd.rd_src = RD_REQ;
      case (state_ff)
         S_INIT: begin
            cmd.clear_we  = 1'b1;
            cmd.spr_clear = 1'b1;
            if (status.clear_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (accept) begin
               cmd.capture = 1'b1;
               case (status.req_op)
                  OP_PIXEL, OP_COLUMN: state_in = S_RD0;
                  OP_MOVE:  state_in = status.move_ok ? S_RD0 : S_DONE;
                  OP_READ:  state_in = S_READ;
                  OP_CLEAR: state_in = S_CLEAR;
                  default:  state_in = S_DONE;
               endcase
            end
         end
         S_RD0: begin
            // fetch the sprite row of this column alongside the lower frame byte
            cmd.rd_src    = RD_B0;
            cmd.sprite_rd = 1'b1;
            state_in = S_WR0;
         end
         S_WR0: begin
            // write the lower byte while reading the upper one
            cmd.frame_we_b0 = 1'b1;
            cmd.rd_src = RD_B1;
            state_in = S_WR1;
         end
         S_WR1: begin
            cmd.frame_we_b1 = 1'b1;
            if (status.col_last) begin
               state_in = S_DONE;
            end else begin
               cmd.col_inc = 1'b1;
               state_in = S_RD0;
            end
         end
         S_READ: begin
            state_in = S_DONE;
         end
         S_CLEAR: begin
            cmd.clear_we = 1'b1;
            if (status.clear_last) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            // hold until the output register can take the transaction
            if (rsp_free) begin
               cmd.load_rsp = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   `LSF_ASSERT_NEVER(a_rsp_overrun, cmd.load_rsp && rsp_valid_ff && !rsp_ready, "rsp overrun")
   `LSF_ASSERT(a_wr0_then_wr1, state_ff == S_WR0 |=> state_ff == S_WR1, "upper write skipped")
   `LSF_ASSERT(a_accept_busy, cmd.capture |=> state_ff != S_IDLE, "accept without work")

endmodule
